>>> rtl/utxs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utxs_pkg: shared types and constants of the UTF-8 text sanitizer
// Byte codes, lead-byte ranges, register indexes and the state and
// step-result bundles that pass between the scan logic and the top level.
// ----------------------------------------------------------------------------
package utxs_pkg;

   // register indexes of the configuration port
   localparam logic CSR_OUT_CAPACITY = 1'b0;
   localparam logic CSR_KEEP_NEWLINE = 1'b1;

   localparam logic [15:0] CAPACITY_RESET = 16'd256;

   // byte codes
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_QMARK = 8'h3f;
   localparam logic [7:0] CHAR_DEL   = 8'h7f;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   // lead byte ranges
   localparam logic [7:0] LEAD2_LO = 8'hc2;
   localparam logic [7:0] LEAD2_HI = 8'hdf;
   localparam logic [7:0] LEAD3_LO = 8'he0;
   localparam logic [7:0] LEAD3_HI = 8'hef;
   localparam logic [7:0] LEAD4_LO = 8'hf0;
   localparam logic [7:0] LEAD4_HI = 8'hf4;

   // leads with a narrowed second-byte range
   localparam logic [7:0] LEAD_E0 = 8'he0;
   localparam logic [7:0] LEAD_ED = 8'hed;
   localparam logic [7:0] LEAD_F0 = 8'hf0;
   localparam logic [7:0] LEAD_F4 = 8'hf4;
   localparam logic [7:0] CONT_A0 = 8'ha0;
   localparam logic [7:0] CONT_9F = 8'h9f;
   localparam logic [7:0] CONT_90 = 8'h90;
   localparam logic [7:0] CONT_8F = 8'h8f;

   localparam int MAX_RESULTS = 4;

   // per-string scan state
   typedef struct packed {
      logic [2:0][7:0] pend;
      logic [1:0]      pcount;
      logic [2:0]      slen;
      logic [15:0]     wcount;
      logic            stopped;
   } scan_state_type;

   // result of one input word
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] bytes;
      logic [2:0]                  count;  // words to send, bare marker included
      logic                        bare;   // no real byte: send an end marker
      scan_state_type              next;
   } scan_result_type;

endpackage
`default_nettype wire

>>> rtl/utxs_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utxs_scan: one-byte UTF-8 scan step
// Classifies the incoming byte against the pending sequence, builds the list
// of bytes to emit, applies the capacity limit and forms the next state.
// ----------------------------------------------------------------------------
module utxs_scan import utxs_pkg::*; (
   input  wire logic [7:0]      in_byte,
   input  wire logic            end_of_string,
   input  wire scan_state_type  state,
   input  wire logic [15:0]     out_capacity,
   input  wire logic            keep_newline,
   output scan_result_type      result
);

   always_comb begin
      logic [7:0]                  mapped;
      logic [2:0]                  lead_k;
      logic                        cont_ok;
      logic [4:0]                  fits;
      logic [MAX_RESULTS-1:0][7:0] cand;
      logic [2:0]                  m;
      logic [2:0]                  e;
      logic                        all_or_none;
      logic                        lead_put;
      logic                        lead_pend;
      logic                        store;
      logic                        stop;

      // ASCII cleanup; any high byte that gets here as a put is invalid
      if (in_byte < 8'h80) begin
         if (in_byte == CHAR_LF && keep_newline) begin
            mapped = CHAR_LF;
         end else if (in_byte < CHAR_SPACE || in_byte == CHAR_DEL) begin
            mapped = CHAR_SPACE;
         end else begin
            mapped = in_byte;
         end
      end else begin
         mapped = CHAR_QMARK;
      end

      // sequence length from a lead byte, zero if it cannot lead
      if (in_byte inside {[LEAD2_LO:LEAD2_HI]}) begin
         lead_k = 3'd2;
      end else if (in_byte inside {[LEAD3_LO:LEAD3_HI]}) begin
         lead_k = 3'd3;
      end else if (in_byte inside {[LEAD4_LO:LEAD4_HI]}) begin
         lead_k = 3'd4;
      end else begin
         lead_k = 3'd0;
      end

      // continuation check, with overlong / surrogate / range limits
      cont_ok = (in_byte[7:6] == 2'b10);
      if (state.pcount == 2'd1) begin
         if (state.pend[0] == LEAD_E0 && in_byte < CONT_A0) cont_ok = 1'b0;
         if (state.pend[0] == LEAD_ED && in_byte > CONT_9F) cont_ok = 1'b0;
         if (state.pend[0] == LEAD_F0 && in_byte < CONT_90) cont_ok = 1'b0;
         if (state.pend[0] == LEAD_F4 && in_byte > CONT_8F) cont_ok = 1'b0;
      end

      // fits[i]: i more bytes still leave room for the terminator
      fits[0] = 1'b1;
      for (int i = 1; i <= MAX_RESULTS; i++) begin
         fits[i] = ({1'b0, state.wcount} + 17'(i)) < {1'b0, out_capacity};
      end

      // candidate byte list
      cand        = {MAX_RESULTS{CHAR_QMARK}};
      m           = 3'd0;
      all_or_none = 1'b0;
      lead_put    = 1'b0;
      lead_pend   = 1'b0;
      store       = 1'b0;
      if (!state.stopped) begin
         if (state.pcount == 2'd0 || !cont_ok) begin
            // flush held bytes as '?', then treat this byte as a fresh lead
            lead_put  = (lead_k == 3'd0);
            lead_pend = !lead_put;
            if (lead_put) cand[state.pcount] = mapped;
            m = {1'b0, state.pcount} + 3'(lead_put || end_of_string);
         end else if ({1'b0, state.pcount} + 3'd1 >= state.slen) begin
            // sequence complete: goes out whole or not at all
            all_or_none = 1'b1;
            cand[0] = state.pend[0];
            cand[1] = (state.pcount >= 2'd2) ? state.pend[1] : in_byte;
            cand[2] = (state.pcount == 2'd3) ? state.pend[2] : in_byte;
            cand[3] = in_byte;
            m = {1'b0, state.pcount} + 3'd1;
         end else begin
            // hold the byte; a cut-off sequence turns into '?' each
            store = 1'b1;
            m     = end_of_string ? ({1'b0, state.pcount} + 3'd1) : 3'd0;
         end
      end

      // emitted count and stop
      stop = !fits[m];
      e    = 3'd0;
      if (all_or_none) begin
         e = fits[m] ? m : 3'd0;
      end else begin
         for (int i = 1; i <= MAX_RESULTS; i++) begin
            if (3'(i) <= m && fits[i]) e = 3'(i);
         end
      end

      result.bytes = cand;
      result.bare  = (e == 3'd0);
      result.count = (e == 3'd0 && end_of_string) ? 3'd1 : e;

      // next state
      result.next = state;
      if (end_of_string) begin
         result.next.pcount  = 2'd0;
         result.next.slen    = 3'd0;
         result.next.wcount  = 16'd0;
         result.next.stopped = 1'b0;
      end else if (!state.stopped) begin
         result.next.wcount  = state.wcount + 16'(e);
         result.next.stopped = stop;
         if (stop) begin
            result.next.pcount = 2'd0;
         end else if (lead_pend) begin
            result.next.pcount  = 2'd1;
            result.next.slen    = lead_k;
            result.next.pend[0] = in_byte;
         end else if (store) begin
            case (state.pcount)
               2'd1: begin
                  result.next.pend[1] = in_byte;
               end
               2'd2: begin
                  result.next.pend[2] = in_byte;
               end
               default: begin
                  result.next.pend[0] = in_byte;
               end
            endcase
            result.next.pcount = state.pcount + 2'd1;
         end else begin
            result.next.pcount = 2'd0;
         end
      end
   end

endmodule
`default_nettype wire

>>> rtl/utf8_text_sanitizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_text_sanitizer: streaming UTF-8 validator and text cleaner
// Takes one byte per word, passes valid UTF-8, turns invalid bytes into '?',
// maps controls to space (LF kept if set) and caps output at out_capacity - 1.
// ----------------------------------------------------------------------------
// Each request word is scanned in the cycle it is accepted and its results,
// zero to four response words, land in a result buffer that drains one word
// per cycle while rsp_stall is low. A request is taken in every cycle while
// each byte yields at most one response word and rsp_stall stays low; a byte
// that completes a multibyte sequence or flushes held bytes holds the
// response side until its last word (of up to four) leaves, and the next
// request is taken in the cycle that word leaves. Results are registered.
module utf8_text_sanitizer import utxs_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_end_of_string,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_byte_valid,
   output logic             rsp_last_result,
   output logic [15:0]      rsp_out_length,
   // configuration
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   scan_state_type  state_ff, state_in;
   scan_result_type step;

   logic [15:0] capacity_ff, capacity_in;
   logic        keep_nl_ff, keep_nl_in;

   logic                        bnd_valid_ff, bnd_valid_in;
   logic [2:0]                  bnd_count_ff, bnd_count_in;
   logic [1:0]                  bnd_idx_ff, bnd_idx_in;
   logic [MAX_RESULTS-1:0][7:0] bnd_bytes_ff, bnd_bytes_in;
   logic [15:0]                 bnd_base_ff, bnd_base_in;
   logic                        bnd_eos_ff, bnd_eos_in;
   logic                        bnd_bare_ff, bnd_bare_in;

   logic take, last_take, accept, bnd_last;

   // scan step
   utxs_scan u_scan (
      .in_byte       (req_in_byte),
      .end_of_string (req_end_of_string),
      .state         (state_ff),
      .out_capacity  (capacity_ff),
      .keep_newline  (keep_nl_ff),
      .result        (step)
   );

   // handshake
   assign bnd_last  = ({1'b0, bnd_idx_ff} == bnd_count_ff - 3'd1);
   assign take      = bnd_valid_ff && !rsp_stall;
   assign last_take = take && bnd_last;
   assign req_stall = bnd_valid_ff && !last_take;
   assign accept    = req_valid && !req_stall;

   // configuration registers
   always_comb begin
      capacity_in = capacity_ff;
      keep_nl_in  = keep_nl_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_OUT_CAPACITY: capacity_in = csr_wdata;
            CSR_KEEP_NEWLINE: keep_nl_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // scan state
   assign state_in = accept ? step.next : state_ff;

   // result buffer
   always_comb begin
      bnd_valid_in = bnd_valid_ff;
      bnd_count_in = bnd_count_ff;
      bnd_idx_in   = bnd_idx_ff;
      bnd_bytes_in = bnd_bytes_ff;
      bnd_base_in  = bnd_base_ff;
      bnd_eos_in   = bnd_eos_ff;
      bnd_bare_in  = bnd_bare_ff;
      if (take) begin
         bnd_idx_in = bnd_idx_ff + 2'd1;
         if (bnd_last) bnd_valid_in = 1'b0;
      end
      if (accept && step.count != 3'd0) begin
         bnd_valid_in = 1'b1;
         bnd_count_in = step.count;
         bnd_idx_in   = 2'd0;
         bnd_bytes_in = step.bytes;
         bnd_base_in  = state_ff.wcount;
         bnd_eos_in   = req_end_of_string;
         bnd_bare_in  = step.bare;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.pcount  <= 2'd0;
         state_ff.slen    <= 3'd0;
         state_ff.wcount  <= 16'd0;
         state_ff.stopped <= 1'b0;
         capacity_ff      <= CAPACITY_RESET;
         keep_nl_ff       <= 1'b0;
         bnd_valid_ff     <= 1'b0;
         bnd_idx_ff       <= 2'd0;
         bnd_count_ff     <= 3'd0;
      end else begin
         state_ff.pcount  <= state_in.pcount;
         state_ff.slen    <= state_in.slen;
         state_ff.wcount  <= state_in.wcount;
         state_ff.stopped <= state_in.stopped;
         capacity_ff      <= capacity_in;
         keep_nl_ff       <= keep_nl_in;
         bnd_valid_ff     <= bnd_valid_in;
         bnd_idx_ff       <= bnd_idx_in;
         bnd_count_ff     <= bnd_count_in;
      end
      state_ff.pend <= state_in.pend;
      bnd_bytes_ff  <= bnd_bytes_in;
      bnd_base_ff   <= bnd_base_in;
      bnd_eos_ff    <= bnd_eos_in;
      bnd_bare_ff   <= bnd_bare_in;
   end

   // response word
   assign rsp_valid       = bnd_valid_ff;
   assign rsp_out_byte    = bnd_bare_ff ? CHAR_NUL : bnd_bytes_ff[bnd_idx_ff];
   assign rsp_byte_valid  = !bnd_bare_ff;
   assign rsp_last_result = bnd_eos_ff && bnd_last;
   assign rsp_out_length  = bnd_bare_ff ? bnd_base_ff
                                        : bnd_base_ff + {14'd0, bnd_idx_ff} + 16'd1;

   // checks
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      bnd_valid_ff |-> ({1'b0, bnd_idx_ff} < bnd_count_ff))
      else $error("result index past buffered count");

   a_bare_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_valid) |-> rsp_last_result)
      else $error("end marker without last flag");

   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !bnd_valid_ff |-> !req_stall)
      else $error("request stalled with empty result buffer");

   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_string) |=>
         (state_ff.wcount == 16'd0 && state_ff.pcount == 2'd0 && !state_ff.stopped))
      else $error("string state not cleared after last byte");

endmodule
`default_nettype wire

>>> tb/tb_utf8_text_sanitizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_text_sanitizer: self-checking bench for the UTF-8 text sanitizer
// Streams strings of bytes into the block and predicts every cleaned word
// with a bit-accurate model of the scanner. The model covers held sequences,
// '?' substitution, control-byte mapping and the output capacity cut. Words
// are checked in order. The run covers directed corner strings, then random
// strings under several register settings, with random valid gaps and
// random response stalls in most phases.
// ----------------------------------------------------------------------------
module tb_utf8_text_sanitizer;
   import utxs_pkg::*;

   localparam int STALL_LIMIT   = 1000;  // cycles with no accepted word
   localparam int SETTLE_CYCLES = 8;
   localparam logic [7:0] CONT_LO = 8'h80;
   localparam logic [7:0] CONT_HI = 8'hbf;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        last_result;
      logic [15:0] out_length;
   } clean_word_type;

   // Scoreboard: predicts the cleaned words of each byte and checks them in order
   class utf8_clean_scoreboard;
      logic [15:0] capacity;
      logic        keep_lf;
      logic [7:0]  held [3];
      int unsigned held_n;
      int unsigned seq_len;
      int unsigned written;
      bit          stopped;
      clean_word_type step_words[$];
      clean_word_type clean_words[$];
      int unsigned errors;

      function new();
         capacity = CAPACITY_RESET;
         keep_lf  = 1'b0;
         foreach (held[i]) held[i] = 8'h00;
         errors   = 0;
         end_text();
      endfunction

      function void end_text();
         held_n  = 0;
         seq_len = 0;
         written = 0;
         stopped = 1'b0;
      endfunction

      function void set_reg(logic idx, logic [15:0] data);
         if (idx == CSR_OUT_CAPACITY) capacity = data;
         else keep_lf = data[0];
      endfunction

      function void add_word(logic [7:0] b, logic v);
         clean_word_type w;
         if (step_words.size() < MAX_RESULTS) begin
            w.out_byte    = b;
            w.byte_valid  = v;
            w.last_result = 1'b0;
            w.out_length  = written[15:0];
            step_words.push_back(w);
         end
      endfunction

      // one output byte, unless the capacity cut is hit
      function void emit_char(logic [7:0] b);
         if (stopped) return;
         if (written + 1 >= capacity) begin
            stopped = 1'b1;
            held_n  = 0;
            return;
         end
         written++;
         add_word(b, 1'b1);
      endfunction

      function void open_lead(logic [7:0] c);
         int unsigned k;
         k = 0;
         if (stopped) return;
         if (!c[7]) begin
            if (c == CHAR_LF && keep_lf) emit_char(CHAR_LF);
            else if (c < CHAR_SPACE || c == CHAR_DEL) emit_char(CHAR_SPACE);
            else emit_char(c);
            return;
         end
         if (c >= LEAD2_LO && c <= LEAD2_HI) k = 2;
         else if (c >= LEAD3_LO && c <= LEAD3_HI) k = 3;
         else if (c >= LEAD4_LO && c <= LEAD4_HI) k = 4;
         if (k != 0) begin
            held[0] = c;
            held_n  = 1;
            seq_len = k;
         end else begin
            emit_char(CHAR_QMARK);
         end
      endfunction

      // every held byte of a broken sequence becomes '?'
      function void drop_held();
         int unsigned n;
         n       = held_n;
         held_n  = 0;
         seq_len = 0;
         for (int unsigned i = 0; i < n && i < 3; i++) emit_char(CHAR_QMARK);
      endfunction

      function void note_byte(logic [7:0] b, logic eos);
         logic ok;
         int unsigned n;
         int lastw;
         step_words.delete();
         if (!stopped) begin
            if (held_n == 0) begin
               open_lead(b);
            end else begin
               ok = (b[7:6] == 2'b10);
               // narrowed second byte: overlong, surrogate, above U+10FFFF
               if (held_n == 1) begin
                  if (held[0] == LEAD_E0 && b < CONT_A0) ok = 1'b0;
                  if (held[0] == LEAD_ED && b > CONT_9F) ok = 1'b0;
                  if (held[0] == LEAD_F0 && b < CONT_90) ok = 1'b0;
                  if (held[0] == LEAD_F4 && b > CONT_8F) ok = 1'b0;
               end
               if (!ok) begin
                  drop_held();
                  open_lead(b);
               end else if (held_n + 1 >= seq_len) begin
                  // sequence complete: all of it or nothing
                  n      = held_n;
                  held_n = 0;
                  if (written + n + 1 >= capacity) begin
                     stopped = 1'b1;
                  end else begin
                     for (int unsigned i = 0; i < n; i++) begin
                        written++;
                        add_word(held[i], 1'b1);
                     end
                     written++;
                     add_word(b, 1'b1);
                  end
                  seq_len = 0;
               end else begin
                  held[held_n] = b;
                  held_n++;
               end
            end
         end
         if (eos) begin
            if (!stopped && held_n > 0) drop_held();
            if (step_words.size() == 0) add_word(CHAR_NUL, 1'b0);
            lastw = step_words.size() - 1;
            step_words[lastw].last_result = 1'b1;
            step_words[lastw].out_length  = written[15:0];
         end
         foreach (step_words[i]) clean_words.push_back(step_words[i]);
         if (eos) end_text();
      endfunction

      function void check_word(clean_word_type got);
         clean_word_type exp;
         if (clean_words.size() == 0) begin
            if (errors < 10)
               $display("unexpected word: byte %h valid %0d last %0d length %0d",
                        got.out_byte, got.byte_valid, got.last_result, got.out_length);
            errors++;
            return;
         end
         exp = clean_words.pop_front();
         if (got.out_byte !== exp.out_byte || got.byte_valid !== exp.byte_valid ||
             got.last_result !== exp.last_result || got.out_length !== exp.out_length) begin
            if (errors < 10)
               $display("mismatch exp/got: byte %h/%h valid %0d/%0d last %0d/%0d len %0d/%0d",
                        exp.out_byte, got.out_byte, exp.byte_valid, got.byte_valid,
                        exp.last_result, got.last_result, exp.out_length, got.out_length);
            errors++;
         end
      endfunction

      function int outstanding();
         return clean_words.size();
      endfunction

      function void close();
         if (clean_words.size() != 0) begin
            if (errors < 10) $display("%0d expected words never came", clean_words.size());
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_end_of_string = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_last_result;
   logic [15:0] rsp_out_length;
   logic        csr_write = 1'b0;
   logic        csr_index = CSR_OUT_CAPACITY;
   logic [15:0] csr_wdata = 16'h0000;

   utf8_clean_scoreboard words = new();
   logic [7:0]  text_bytes[$];
   bit          idle_on = 1'b1;
   int          stall_left = 0;
   int          idle_cycles = 0;
   clean_word_type mon_word;
   bit          mon_busy;

   utf8_text_sanitizer i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_last_result   (rsp_last_result),
      .rsp_out_length    (rsp_out_length),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response stall in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 9);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: results are checked before the same-edge input is noted
   always @(posedge clock) begin
      if (!reset) begin
         mon_busy = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            mon_word.out_byte    = rsp_out_byte;
            mon_word.byte_valid  = rsp_byte_valid;
            mon_word.last_result = rsp_last_result;
            mon_word.out_length  = rsp_out_length;
            words.check_word(mon_word);
            mon_busy = 1'b1;
         end
         if (req_valid && !req_stall) begin
            words.note_byte(req_in_byte, req_end_of_string);
            mon_busy = 1'b1;
         end
         idle_cycles = mon_busy ? 0 : idle_cycles + 1;
      end
   end

   // watchdog
   initial begin
      do @(posedge clock); while (idle_cycles < STALL_LIMIT);
      $display("FAILURE");
      $finish;
   end

   function automatic logic [7:0] rand_byte(logic [7:0] lo, logic [7:0] hi);
      return 8'($urandom_range(hi, lo));
   endfunction

   // a well-formed sequence of len bytes
   function automatic void push_seq(int len);
      logic [7:0] lead, lo, hi;
      case (len)
         2:       lead = rand_byte(LEAD2_LO, LEAD2_HI);
         3:       lead = rand_byte(LEAD3_LO, LEAD3_HI);
         default: lead = rand_byte(LEAD4_LO, LEAD4_HI);
      endcase
      lo = CONT_LO;
      hi = CONT_HI;
      if (lead == LEAD_E0) lo = CONT_A0;
      if (lead == LEAD_ED) hi = CONT_9F;
      if (lead == LEAD_F0) lo = CONT_90;
      if (lead == LEAD_F4) hi = CONT_8F;
      text_bytes.push_back(lead);
      text_bytes.push_back(rand_byte(lo, hi));
      repeat (len - 2) text_bytes.push_back(rand_byte(CONT_LO, CONT_HI));
   endfunction

   function automatic void push_prefix(int len);
      push_seq(len);
      repeat ($urandom_range(1, len - 1)) text_bytes.delete(text_bytes.size() - 1);
   endfunction

   // random string of 1 to 8 characters and an optional cut-off tail, mostly well formed
   function automatic void build_text();
      int pick;
      text_bytes.delete();
      repeat ($urandom_range(1, 8)) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) text_bytes.push_back(rand_byte(CHAR_SPACE, 8'h7e));
         else if (pick < 38)
            text_bytes.push_back($urandom_range(0, 4) == 0 ? CHAR_DEL : rand_byte(8'h00, 8'h1f));
         else if (pick < 44) text_bytes.push_back(CHAR_LF);
         else if (pick < 76) push_seq($urandom_range(2, 4));
         else if (pick < 86) begin
            // sequence broken by a non-continuation byte
            push_prefix($urandom_range(2, 4));
            text_bytes.push_back($urandom_range(0, 1) ? rand_byte(8'h00, CHAR_DEL)
                                                      : rand_byte(8'hc0, 8'hff));
         end else if (pick < 91) begin
            // second byte outside the narrowed range
            case ($urandom_range(0, 3))
               0: begin
                  text_bytes.push_back(LEAD_E0);
                  text_bytes.push_back(rand_byte(CONT_LO, CONT_9F));
               end
               1: begin
                  text_bytes.push_back(LEAD_ED);
                  text_bytes.push_back(rand_byte(CONT_A0, CONT_HI));
               end
               2: begin
                  text_bytes.push_back(LEAD_F0);
                  text_bytes.push_back(rand_byte(CONT_LO, CONT_8F));
               end
               default: begin
                  text_bytes.push_back(LEAD_F4);
                  text_bytes.push_back(rand_byte(CONT_90, CONT_HI));
               end
            endcase
            text_bytes.push_back(rand_byte(CONT_LO, CONT_HI));
         end else text_bytes.push_back(rand_byte(8'h00, 8'hff));
      end
      // sequence cut off by the end of the string
      if ($urandom_range(0, 5) == 0) push_prefix($urandom_range(2, 4));
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_in_byte       <= b;
      req_end_of_string <= last;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_text();
      foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (words.outstanding() != 0);
   endtask

   task automatic settle();
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // both registers, back to back; only called while the block is idle
   task automatic write_regs(input logic [15:0] cap, input logic keep);
      csr_write <= 1'b1;
      csr_index <= CSR_OUT_CAPACITY;
      csr_wdata <= cap;
      @(posedge clock);
      words.set_reg(CSR_OUT_CAPACITY, cap);
      csr_index <= CSR_KEEP_NEWLINE;
      csr_wdata <= {15'd0, keep};
      @(posedge clock);
      words.set_reg(CSR_KEEP_NEWLINE, {15'd0, keep});
      csr_write <= 1'b0;
   endtask

   task automatic run_phase(input logic [15:0] cap, input logic keep, input bit idling,
                            input int target, input bit pressure);
      int sent;
      int strings;
      sent    = 0;
      strings = 0;
      idle_on = idling;
      write_regs(cap, keep);
      while (sent < target) begin
         build_text();
         send_text();
         sent += text_bytes.size();
         // hold the sender until the block has drained
         if (pressure && (strings == 0 || $urandom_range(0, 3) == 0)) wait_results();
         strings++;
      end
      settle();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // controls, DEL, newline mapped to space, widest valid sequences
      write_regs(16'hffff, 1'b0);
      text_bytes = '{8'h00, 8'h1f, CHAR_LF, CHAR_DEL, 8'h7e};
      send_text();
      text_bytes = '{LEAD2_LO, CONT_LO, LEAD4_HI, CONT_8F, CONT_HI, CONT_HI};
      send_text();
      // overlong, surrogate, too large, bad leads, stray continuation, cut-off tail
      text_bytes = '{LEAD_E0, CONT_9F, LEAD_ED, CONT_A0, LEAD_F0, CONT_8F, LEAD_F4, CONT_90,
                     8'hc1, 8'hf5, CONT_LO, 8'he1, CONT_LO};
      send_text();
      settle();

      // newline kept; capacity cut drops a whole sequence, string ends bare
      write_regs(16'd3, 1'b1);
      text_bytes = '{CHAR_LF, 8'h41, 8'hc3, 8'ha9};
      send_text();
      settle();

      run_phase(16'hffff, 1'b1, 1'b1, 40, 1'b0);
      run_phase(16'd0, 1'b0, 1'b1, 15, 1'b0);
      run_phase(16'd1, 1'b1, 1'b1, 15, 1'b0);
      run_phase(16'($urandom_range(2, 12)), 1'($urandom_range(0, 1)), 1'b1, 40, 1'b1);
      run_phase(16'($urandom_range(4, 24)), 1'($urandom_range(0, 1)), 1'b0, 30, 1'b0);
      run_phase(CAPACITY_RESET, 1'b0, 1'b1, 40, 1'b0);
      run_phase(16'hffff, 1'b0, 1'b0, 40, 1'b0);

      words.close();
      if (words.errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
